>>> design/dmks_pkg.sv
// Shared widths, codes and types for the direct-mapped keyed store.
package dmks_pkg;

  localparam int MODE_W      = 2;
  localparam int KEY_W       = 31;
  localparam int NAME_W      = 64;
  localparam int PRICE_W     = 32;
  localparam int STATUS_W    = 3;
  localparam int COUNT_OUT_W = 7;

  localparam int SLOTS_DEF    = 64;
  localparam int CAPACITY_DEF = 64;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_UPDATE = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_FULL    = 3'd1,
    STAT_COLLIDE = 3'd2,
    STAT_DUP     = 3'd3,
    STAT_MISSING = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [NAME_W-1:0]  name;
    logic [PRICE_W-1:0] price;
  } slot_entry_t;

endpackage

>>> design/dmks_if.sv
// Request and response channel interfaces of the keyed store.
interface dmks_req_if import dmks_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [KEY_W-1:0]   key;
  logic [NAME_W-1:0]  name_payload;
  logic [PRICE_W-1:0] price_bits;

  modport source (output valid, mode, key, name_payload, price_bits, input ready);
  modport sink (input valid, mode, key, name_payload, price_bits, output ready);
endinterface

interface dmks_rsp_if import dmks_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic                   found;
  logic [NAME_W-1:0]      name_out;
  logic [PRICE_W-1:0]     price_out;
  logic [COUNT_OUT_W-1:0] entry_count;

  modport source (output valid, status, found, name_out, price_out, entry_count,
                  input ready);
  modport sink (input valid, status, found, name_out, price_out, entry_count,
                output ready);
endinterface

>>> design/dmks_slot_mod.sv
// Key-to-slot reduction: mask for a power-of-two slot count, else reciprocal multiplication.
module dmks_slot_mod import dmks_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [KEY_W-1:0]         key,
  output logic                     busy,
  output logic [$clog2(SLOTS)-1:0] slot
);

  localparam int IDXW = $clog2(SLOTS);

  generate
    if ((SLOTS & (SLOTS - 1)) == 0) begin : g_pow2
      always_ff @(posedge clk) begin
        if (start) begin
          slot <= key[IDXW-1:0];
        end
      end
      assign busy = 1'b0;
    end else begin : g_recip
      // Quotient from a rounded-up reciprocal, exact for every KEY_W-bit key;
      // the remainder is registered in the cycle after, as key - quotient * SLOTS
      localparam int SHIFT = KEY_W + IDXW;
      localparam longint unsigned RECIP_WIDE =
        ((64'd1 << SHIFT) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
      localparam logic [KEY_W:0]   RECIP   = (KEY_W + 1)'(RECIP_WIDE);
      localparam logic [KEY_W-1:0] DIVISOR = KEY_W'(SLOTS);

      logic [2*KEY_W:0] prod;
      logic [KEY_W-1:0] key_s;
      logic             run;
      logic [KEY_W-1:0] quot;
      logic [KEY_W-1:0] diff;

      assign quot = KEY_W'(prod >> SHIFT);
      assign diff = key_s - quot * DIVISOR;

      always_ff @(posedge clk) begin
        if (rst) begin
          run <= 1'b0;
        end else begin
          run <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          prod  <= {{(KEY_W+1){1'b0}}, key} * {{KEY_W{1'b0}}, RECIP};
          key_s <= key;
        end
        if (run) begin
          slot <= diff[IDXW-1:0];
        end
      end

      assign busy = run;
    end
  endgenerate

endmodule

>>> design/dmks_slot_ram.sv
// Slot memory: one write port, one read port with registered read data.
module dmks_slot_ram import dmks_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(SLOTS)-1:0] wr_addr,
  input  slot_entry_t              wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(SLOTS)-1:0] rd_addr,
  output slot_entry_t              rd_data
);

  slot_entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/direct_mapped_keyed_store.sv
// Top level of the direct-mapped keyed store: control, slot update and result register.
//
//  channel | dir | transfer carries
//  --------+-----+------------------------------------------------------------
//  req     | in  | mode, key, name_payload, price_bits
//  rsp     | out | status, found, name_out, price_out, entry_count
//
// One request at a time. For a power-of-two SLOTS a request passes through
// accept, slot read, then check/write-back and result load. Otherwise the
// reciprocal-multiply remainder unit adds a remainder step before the read.
// Reset runs a clearing pass over every slot of the slot memory; req.ready
// stays low until it ends. A result waits in the output register; only the
// final step stalls while that register is still full.
module direct_mapped_keyed_store import dmks_pkg::*; #(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  dmks_req_if.sink   req,
  dmks_rsp_if.source rsp
);

  localparam int IDXW = $clog2(SLOTS);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam logic [IDXW-1:0] LAST_SLOT = IDXW'(SLOTS - 1);
  localparam logic [CW-1:0]   CAP_LIM   = CW'(CAPACITY);

  state_t state, state_next;

  // Request held for the duration of its processing
  mode_t              mode_q;
  logic [KEY_W-1:0]   key_q;
  logic [NAME_W-1:0]  name_q;
  logic [PRICE_W-1:0] price_q;

  logic [IDXW-1:0] clr_addr;
  logic [CW-1:0]   count, count_next;

  logic            accept;
  logic            mod_busy;
  logic [IDXW-1:0] slot;

  logic            wr_en, rd_en;
  logic [IDXW-1:0] wr_addr;
  slot_entry_t     wr_data, rd_data;

  logic        load;
  logic        match;
  status_t     status_c;
  slot_entry_t upd_entry;
  logic        upd_en;

  assign accept = req.valid && req.ready;

  dmks_slot_mod #(.SLOTS(SLOTS)) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .key   (req.key),
    .busy  (mod_busy),
    .slot  (slot)
  );

  dmks_slot_ram #(.SLOTS(SLOTS)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (slot),
    .rd_data (rd_data)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == LAST_SLOT) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_next = S_DIV;
      end
      S_DIV: begin
        if (!mod_busy) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (load) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Evaluate the request against the entry read from its slot
  always_comb begin
    match      = rd_data.valid && (rd_data.key == key_q);
    status_c   = STAT_OK;
    upd_en     = 1'b0;
    upd_entry  = rd_data;
    count_next = count;
    unique case (mode_q)
      MODE_INSERT: begin
        priority if (count >= CAP_LIM) begin
          status_c = STAT_FULL;
        end else if (rd_data.valid && !match) begin
          status_c = STAT_COLLIDE;
        end else if (match) begin
          status_c = STAT_DUP;
        end else begin
          upd_en     = 1'b1;
          upd_entry  = '{valid: 1'b1, key: key_q, name: name_q, price: price_q};
          count_next = count + 1'b1;
        end
      end
      MODE_DELETE: begin
        if (match) begin
          upd_en          = 1'b1;
          upd_entry.valid = 1'b0;
          count_next      = count - 1'b1;
        end else begin
          status_c = STAT_MISSING;
        end
      end
      MODE_SEARCH: begin
        if (!match) status_c = STAT_MISSING;
      end
      MODE_UPDATE: begin
        if (match) begin
          upd_en          = 1'b1;
          upd_entry.name  = name_q;
          upd_entry.price = price_q;
        end else begin
          status_c = STAT_MISSING;
        end
      end
      default: status_c = STAT_MISSING;
    endcase
  end

  // Outputs of the controller
  always_comb begin
    req.ready = 1'b0;
    rd_en     = 1'b0;
    load      = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = slot;
    wr_data   = upd_entry;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
      end
      S_IDLE: begin
        req.ready = 1'b1;
      end
      S_DIV: begin
        rd_en = !mod_busy;
      end
      S_EXEC: begin
        // Hold the write-back until the result register is free
        load  = !rsp.valid || rsp.ready;
        wr_en = load && upd_en;
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == S_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q  <= mode_t'(req.mode);
      key_q   <= req.key;
      name_q  <= req.name_payload;
      price_q <= req.price_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.status      <= status_c;
      rsp.found       <= match;
      rsp.name_out    <= (mode_q == MODE_SEARCH && match) ? rd_data.name : '0;
      rsp.price_out   <= (mode_q == MODE_SEARCH && match) ? rd_data.price : '0;
      rsp.entry_count <= COUNT_OUT_W'(count_next);
    end
  end

`ifndef ASSERT_OFF
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_LIM)
    else $error("live count above capacity");

  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_CLEAR || state == S_EXEC))
    else $error("slot write outside clear or update step");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (load && mode_q == MODE_INSERT && status_c == STAT_OK) |=>
      (count == $past(count) + 1'b1))
    else $error("successful insert did not advance count");

  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.found) |-> (rsp.name_out == '0 && rsp.price_out == '0))
    else $error("payload returned without a key match");

  a_ok_search: assert property (@(posedge clk) disable iff (rst)
    (load && mode_q == MODE_SEARCH && status_c == STAT_OK) |-> match)
    else $error("search reported ok without a match");
`endif

endmodule
